/* rtl/trd_pkg.sv */
// ----------------------------------------------------------------------------
// trd_pkg
// Types and constants shared by the tandem repeat detector files.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int MAX_BLOCK_DEF   = 64;
    localparam int SYMBOL_BITS_DEF = 32;

    localparam int BLK_W = 7;
    localparam int TOK_W = 32;
    localparam int CNT_W = 32;

    localparam logic [BLK_W-1:0] BLK_RESET  = 7'd1;
    localparam logic [CNT_W-1:0] REPEAT_MIN = 32'd2;
    localparam logic [CNT_W-1:0] CNT_SAT    = '1;

    typedef struct packed {
        logic [TOK_W-1:0] symbol_id;
        logic             end_of_sequence;
    } in_beat_t;

    typedef struct packed {
        logic [CNT_W-1:0] repeat_start;
        logic [CNT_W-1:0] repeat_count;
    } out_beat_t;

endpackage

/* rtl/trd_ram.sv */
// ----------------------------------------------------------------------------
// trd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/trd_core.sv */
// ----------------------------------------------------------------------------
// trd_core
// Sequence state, history RAM and the per-beat compare and repeat tracking.
// ----------------------------------------------------------------------------
module trd_core #(
    parameter int MAX_BLOCK   = trd_pkg::MAX_BLOCK_DEF,
    parameter int SYMBOL_BITS = trd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [trd_pkg::BLK_W-1:0] cfg_wdata,
    input  logic                      step,
    input  trd_pkg::in_beat_t         beat,
    output logic                      hit,
    output trd_pkg::out_beat_t        result
);

    localparam int SYM_W = SYMBOL_BITS < trd_pkg::TOK_W ? SYMBOL_BITS : trd_pkg::TOK_W;
    localparam int AW    = MAX_BLOCK > 1 ? $clog2(MAX_BLOCK) : 1;
    localparam int BW    = trd_pkg::BLK_W;
    localparam int CW    = trd_pkg::CNT_W;
    localparam logic [AW-1:0] WP_LAST = AW'(MAX_BLOCK - 1);

    logic [BW-1:0]    blk_reg, blk_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [BW-1:0]    run_reg, run_next;
    logic [CW-1:0]    floor_reg, floor_next;
    logic             rep_reg, rep_next;
    logic [CW-1:0]    rs_reg, rs_next;
    logic [CW-1:0]    tally_reg, tally_next;
    logic [CW-1:0]    end_reg, end_next;
    logic [BW-1:0]    ph_reg, ph_next;
    logic [SYM_W-1:0] last_reg;

    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] ram_rdata;
    logic [SYM_W-1:0] hist;
    logic [AW-1:0]    rd_addr;
    logic             active;
    logic             match;
    logic [BW-1:0]    run_inc;
    logic [BW:0]      ph_inc;
    logic [CW:0]      second;
    logic [CW:0]      end_sum;
    logic [CW:0]      pos_sum;
    int               rd_tmp;

    assign sym    = beat.symbol_id[SYM_W-1:0];
    assign active = (blk_reg != '0) && (int'(blk_reg) <= MAX_BLOCK);
    assign hist   = (blk_reg == BW'(1)) ? last_reg : ram_rdata;
    assign match  = active && (pos_reg >= CW'(blk_reg)) && (hist == sym);

    always_comb begin
        blk_next   = blk_reg;
        wp_next    = wp_reg;
        pos_next   = pos_reg;
        run_next   = run_reg;
        floor_next = floor_reg;
        rep_next   = rep_reg;
        rs_next    = rs_reg;
        tally_next = tally_reg;
        end_next   = end_reg;
        ph_next    = ph_reg;
        hit        = 1'b0;
        result     = '0;
        run_inc    = (run_reg < blk_reg) ? run_reg + BW'(1) : run_reg;
        ph_inc     = {1'b0, ph_reg} + (BW+1)'(1);
        second     = {1'b0, pos_reg} + (CW+1)'(1) - (CW+1)'(blk_reg);
        end_sum    = {1'b0, end_reg} + (CW+1)'(blk_reg);
        pos_sum    = {1'b0, pos_reg} + (CW+1)'(1);

        if (cfg_we) begin
            blk_next   = cfg_wdata;
            wp_next    = '0;
            pos_next   = '0;
            run_next   = '0;
            floor_next = '0;
            rep_next   = 1'b0;
            rs_next    = '0;
            tally_next = '0;
            end_next   = '0;
            ph_next    = '0;
        end else if (step) begin
            if (active) begin
                if (rep_reg) begin
                    if (match) begin
                        ph_next = ph_inc[BW-1:0];
                        if (ph_inc >= {1'b0, blk_reg}) begin
                            ph_next = '0;
                            if (tally_reg != trd_pkg::CNT_SAT) begin
                                tally_next = tally_reg + CW'(1);
                                end_next   = end_sum[CW] ? trd_pkg::CNT_SAT : end_sum[CW-1:0];
                            end
                        end
                    end else begin
                        hit                 = 1'b1;
                        result.repeat_start = rs_reg;
                        result.repeat_count = tally_reg;
                        floor_next          = end_reg;
                        rep_next            = 1'b0;
                        run_next            = '0;
                        ph_next             = '0;
                    end
                end else if (match) begin
                    run_next = run_inc;
                    if (run_inc >= blk_reg) begin
                        if (second >= (CW+1)'(blk_reg) && second >= {1'b0, floor_reg}) begin
                            rep_next   = 1'b1;
                            rs_next    = second[CW-1:0] - CW'(blk_reg);
                            tally_next = trd_pkg::REPEAT_MIN;
                            ph_next    = '0;
                            end_next   = pos_sum[CW] ? trd_pkg::CNT_SAT : pos_sum[CW-1:0];
                        end
                    end
                end else begin
                    run_next = '0;
                end
            end

            wp_next  = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);
            pos_next = pos_sum[CW] ? trd_pkg::CNT_SAT : pos_sum[CW-1:0];

            if (beat.end_of_sequence) begin
                if (rep_next && !hit) begin
                    hit                 = 1'b1;
                    result.repeat_start = rs_next;
                    result.repeat_count = tally_next;
                end
                wp_next    = '0;
                pos_next   = '0;
                run_next   = '0;
                floor_next = '0;
                rep_next   = 1'b0;
                rs_next    = '0;
                tally_next = '0;
                end_next   = '0;
                ph_next    = '0;
            end
        end
    end

    // prefetch the entry one block behind the next write slot
    always_comb begin
        rd_tmp = int'(wp_next) + MAX_BLOCK - int'(blk_next);
        if (rd_tmp >= MAX_BLOCK) begin
            rd_tmp = rd_tmp - MAX_BLOCK;
        end
        if (blk_next == '0 || int'(blk_next) > MAX_BLOCK) begin
            rd_tmp = 0;
        end
        rd_addr = rd_tmp[AW-1:0];
    end

    trd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_BLOCK)
    ) u_hist (
        .aclk  (aclk),
        .we    (step && !cfg_we),
        .waddr (wp_reg),
        .wdata (sym),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg   <= trd_pkg::BLK_RESET;
            wp_reg    <= '0;
            pos_reg   <= '0;
            run_reg   <= '0;
            floor_reg <= '0;
            rep_reg   <= 1'b0;
            rs_reg    <= '0;
            tally_reg <= '0;
            end_reg   <= '0;
            ph_reg    <= '0;
        end else begin
            blk_reg   <= blk_next;
            wp_reg    <= wp_next;
            pos_reg   <= pos_next;
            run_reg   <= run_next;
            floor_reg <= floor_next;
            rep_reg   <= rep_next;
            rs_reg    <= rs_next;
            tally_reg <= tally_next;
            end_reg   <= end_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && !cfg_we) begin
            last_reg <= sym;
        end
    end

    a_count_min: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> result.repeat_count >= trd_pkg::REPEAT_MIN)
        else $error("repeat emitted with fewer than two blocks");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !cfg_we && beat.end_of_sequence) |=> (pos_reg == '0 && !rep_reg))
        else $error("sequence state not cleared after last symbol");

    a_start_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_reg |-> (rs_reg < pos_reg))
        else $error("repeat start not behind current position");

    a_rep_active: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_reg |-> active)
        else $error("open repeat with detection disabled");

endmodule

/* rtl/tandem_repeat_detector.sv */
// ----------------------------------------------------------------------------
// tandem_repeat_detector
// Finds back-to-back repeats of a fixed-length block in a token stream.
// ----------------------------------------------------------------------------
// The block takes one symbol beat per clock cycle and reports at most one
// repeat per beat, through the input register and then the result register;
// a result that waits on m_ready holds the input once the input register
// also holds a beat. The rate is set by the single compare of each symbol
// with the one block_length places back, read from the history RAM, whose
// registered read is prefetched one block behind the next write slot so
// that consecutive beats meet no bubble. No clearing pass follows reset;
// write block_length only while the block is idle.
module tandem_repeat_detector #(
    parameter int MAX_BLOCK   = trd_pkg::MAX_BLOCK_DEF,
    parameter int SYMBOL_BITS = trd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [trd_pkg::BLK_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  trd_pkg::in_beat_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output trd_pkg::out_beat_t        m_data
);

    logic               in_valid_reg, in_valid_next;
    trd_pkg::in_beat_t  in_data_reg;
    logic               out_valid_reg, out_valid_next;
    trd_pkg::out_beat_t out_data_reg;
    logic               fire;
    logic               hit;
    trd_pkg::out_beat_t result;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = hit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    trd_core #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (fire),
        .beat      (in_data_reg),
        .hit       (hit),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads until the next beat moves
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire && hit) begin
            out_data_reg <= result;
        end
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tandem repeat detector. A short table of
// directed beats covers reset behaviour, token extremes and disabled block
// lengths. Random phases follow, one block length each, and drive sequences
// of repeated blocks with partial tails, corrupted symbols and noise. Every
// result beat is checked against the table or an in-bench detector model.
// Both ends idle at random; one phase holds the result side off at length.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BLK_W          = trd_pkg::BLK_W;
    localparam int TOK_W          = trd_pkg::TOK_W;
    localparam int CNT_W          = trd_pkg::CNT_W;
    localparam int MAX_BLOCK      = trd_pkg::MAX_BLOCK_DEF;
    localparam int RANDOM_ITEMS   = 1125;
    localparam int MAX_IDLE       = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRESSURE_PHASE = 2;
    localparam int PAUSE_PHASE    = 6;

    typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_REPEAT } row_check_e;
    typedef enum logic { ROW_BEAT, ROW_CFG } row_kind_e;

    typedef struct {
        row_kind_e        kind;
        logic [BLK_W-1:0] length;
        logic [TOK_W-1:0] symbol;
        logic             last;
        row_check_e       check;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] count;
    } stim_row_t;

    stim_row_t directed_rows [0:29] = '{
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_005A, 1'b0, CHK_REPEAT, 32'd0, 32'd3},
        '{ROW_BEAT, 7'd0,   32'h0000_005A, 1'b1, CHK_REPEAT, 32'd3, 32'd2},
        '{ROW_BEAT, 7'd0,   32'hFFFF_FFFF, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hFFFF_FFFF, 1'b1, CHK_REPEAT, 32'd0, 32'd2},
        '{ROW_BEAT, 7'd0,   32'h0000_0000, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_0000, 1'b1, CHK_REPEAT, 32'd0, 32'd2},
        '{ROW_BEAT, 7'd0,   32'h1234_5678, 1'b1, CHK_NONE,   32'd0, 32'd0},
        '{ROW_CFG,  7'd2,   32'h0,         1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hC0DE_0001, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hC0DE_0002, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hC0DE_0001, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hC0DE_0002, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hC0DE_0001, 1'b1, CHK_REPEAT, 32'd0, 32'd2},
        '{ROW_CFG,  7'd0,   32'h0,         1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b1, CHK_NONE,   32'd0, 32'd0},
        '{ROW_CFG,  7'd127, 32'h0,         1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h0000_00A5, 1'b1, CHK_NONE,   32'd0, 32'd0},
        '{ROW_CFG,  7'd3,   32'h0,         1'b0, CHK_NONE,   32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h8000_0001, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h4000_0002, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h2000_0004, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h8000_0001, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h4000_0002, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'h2000_0004, 1'b0, CHK_MODEL,  32'd0, 32'd0},
        '{ROW_BEAT, 7'd0,   32'hDEAD_BEEF, 1'b1, CHK_MODEL,  32'd0, 32'd0}
    };

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [BLK_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    trd_pkg::in_beat_t   s_data;
    logic                m_valid;
    logic                m_ready;
    trd_pkg::out_beat_t  m_data;

    // detector model state
    logic [TOK_W-1:0]    det_hist [MAX_BLOCK];
    int unsigned         det_wptr;
    int unsigned         det_run;
    int unsigned         det_phase;
    int unsigned         det_len;
    logic [CNT_W-1:0]    det_pos;
    logic [CNT_W-1:0]    det_floor;
    logic [CNT_W-1:0]    det_start;
    logic [CNT_W-1:0]    det_blocks;
    bit                  det_open;

    trd_pkg::out_beat_t  pending_repeats [$];
    trd_pkg::in_beat_t   phase_beats [$];

    bit                  hold_req = 1'b0;
    bit                  send_steady = 1'b0;
    bit                  recv_steady = 1'b0;
    int unsigned         cycle_count = 0;
    int unsigned         mismatches = 0;
    int unsigned         repeats_seen = 0;
    int unsigned         symbols_fed = 0;
    int unsigned         lengths_written = 0;

    tandem_repeat_detector #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SYMBOL_BITS (trd_pkg::SYMBOL_BITS_DEF)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d repeats outstanding",
                     cycle_count, pending_repeats.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void clear_detector();
        det_wptr   = 0;
        det_pos    = '0;
        det_run    = 0;
        det_floor  = '0;
        det_open   = 1'b0;
        det_start  = '0;
        det_blocks = '0;
        det_phase  = 0;
    endfunction

    function automatic void apply_block_length(input logic [BLK_W-1:0] len);
        det_len = len;
        clear_detector();
    endfunction

    function automatic void step_detector(input trd_pkg::in_beat_t beat, output bit found,
                                          output trd_pkg::out_beat_t rep);
        int unsigned     c;
        bit              hit;
        longint unsigned second;
        longint unsigned reach;
        c     = det_len;
        found = 1'b0;
        rep   = '0;
        hit   = 1'b0;
        if (c != 0 && c <= MAX_BLOCK) begin
            if (det_pos >= c)
                hit = det_hist[(det_wptr + MAX_BLOCK - c) % MAX_BLOCK] == beat.symbol_id;
            if (det_open) begin
                if (hit) begin
                    det_phase++;
                    if (det_phase >= c) begin
                        det_phase = 0;
                        if (det_blocks != trd_pkg::CNT_SAT)
                            det_blocks++;
                    end
                end else begin
                    found            = 1'b1;
                    rep.repeat_start = det_start;
                    rep.repeat_count = det_blocks;
                    reach     = 64'(det_start) + 64'(det_blocks) * 64'(c);
                    det_floor = (reach > trd_pkg::CNT_SAT) ? trd_pkg::CNT_SAT
                                                           : reach[CNT_W-1:0];
                    det_open  = 1'b0;
                    det_run   = 0;
                    det_phase = 0;
                end
            end else if (hit) begin
                if (det_run < c)
                    det_run++;
                if (det_run >= c) begin
                    second = 64'(det_pos) + 1 - c;
                    if (second >= c && second >= det_floor) begin
                        det_open   = 1'b1;
                        det_start  = CNT_W'(second - c);
                        det_blocks = trd_pkg::REPEAT_MIN;
                        det_phase  = 0;
                    end
                end
            end else begin
                det_run = 0;
            end
        end
        det_hist[det_wptr] = beat.symbol_id;
        det_wptr = (det_wptr + 1) % MAX_BLOCK;
        if (det_pos != trd_pkg::CNT_SAT)
            det_pos++;
        if (beat.end_of_sequence) begin
            if (det_open && !found) begin
                found            = 1'b1;
                rep.repeat_start = det_start;
                rep.repeat_count = det_blocks;
            end
            clear_detector();
        end
    endfunction

    function automatic int unsigned sender_gap();
        return send_steady ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic logic [BLK_W-1:0] pick_block_length(input int unsigned ph);
        case (ph % 12)
            0:       return 7'd1;
            1:       return 7'd2;
            2:       return 7'd1;
            3:       return 7'd3;
            4:       return 7'd64;
            5:       return 7'd0;
            6:       return 7'd4;
            7:       return BLK_W'($urandom_range(5, 63));
            8:       return 7'd2;
            9:       return BLK_W'($urandom_range(65, 127));
            10:      return 7'd8;
            default: return 7'd1;
        endcase
    endfunction

    function automatic void add_beat(input logic [TOK_W-1:0] sym);
        trd_pkg::in_beat_t b;
        b.symbol_id       = sym;
        b.end_of_sequence = 1'b0;
        phase_beats.insert(phase_beats.size(), b);
    endfunction

    task automatic settle_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_repeats.size() != 0);
    endtask

    task automatic write_block_length(input logic [BLK_W-1:0] len);
        settle_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wdata <= len;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        apply_block_length(len);
        lengths_written++;
    endtask

    task automatic feed_symbol(input trd_pkg::in_beat_t beat, input row_check_e check,
                               input trd_pkg::out_beat_t typed);
        int unsigned        gap;
        bit                 found;
        trd_pkg::out_beat_t rep;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        step_detector(beat, found, rep);
        symbols_fed++;
        case (check)
            CHK_MODEL:  if (found) pending_repeats.insert(pending_repeats.size(), rep);
            CHK_REPEAT: pending_repeats.insert(pending_repeats.size(), typed);
            default:    ;
        endcase
    endtask

    task automatic build_phase(input int unsigned len, input int unsigned target);
        logic [TOK_W-1:0] alphabet [4];
        logic [TOK_W-1:0] unit [$];
        int unsigned      span;
        int unsigned      reps;
        int unsigned      cut;
        int unsigned      segs;
        phase_beats.delete();
        foreach (alphabet[k])
            alphabet[k] = $urandom;
        while (phase_beats.size() < target) begin
            span = (len != 0 && len <= MAX_BLOCK) ? len : $urandom_range(1, 8);
            segs = (span > 16) ? 1 : $urandom_range(1, 4);
            repeat (segs) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        unit.delete();
                        repeat (span) unit.insert(unit.size(), alphabet[$urandom_range(0, 3)]);
                        reps = $urandom_range(1, (span > 16) ? 3 : 4);
                        cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : 0;
                        repeat (reps)
                            foreach (unit[j])
                                add_beat(unit[j]);
                        for (int j = 0; j < cut; j++)
                            add_beat(unit[j]);
                        // break a block somewhere now and then
                        if ($urandom_range(0, 4) == 0)
                            phase_beats[$urandom_range(0, phase_beats.size() - 1)].symbol_id =
                                alphabet[$urandom_range(0, 3)];
                    end
                    7, 8: begin
                        repeat ($urandom_range(1, span))
                            add_beat(alphabet[$urandom_range(0, 3)]);
                    end
                    default: begin
                        repeat ($urandom_range(1, 4))
                            add_beat(TOK_W'($urandom));
                    end
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                phase_beats[$].end_of_sequence = 1'b1;
        end
    endtask

    initial begin : result_sink
        int unsigned        stall;
        trd_pkg::out_beat_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = recv_steady ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                for (int k = 0; k < stall; k++)
                    @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && !hold_req);
            if (m_valid) begin
                repeats_seen++;
                if (pending_repeats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected repeat: start %0d count %0d",
                                 m_data.repeat_start, m_data.repeat_count);
                end else begin
                    want = pending_repeats.pop_front();
                    if (m_data.repeat_start !== want.repeat_start ||
                        m_data.repeat_count !== want.repeat_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("repeat mismatch: start exp %0d got %0d, count exp %0d got %0d",
                                     want.repeat_start, m_data.repeat_start,
                                     want.repeat_count, m_data.repeat_count);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        trd_pkg::in_beat_t  beat;
        trd_pkg::out_beat_t typed;
        logic [BLK_W-1:0]   len;
        int unsigned        target;
        int unsigned        phase_no;
        int unsigned        random_items;
        bit                 enabled;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        foreach (det_hist[k])
            det_hist[k] = '0;
        apply_block_length(trd_pkg::BLK_RESET);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_block_length(directed_rows[r].length);
            end else begin
                beat.symbol_id       = directed_rows[r].symbol;
                beat.end_of_sequence = directed_rows[r].last;
                typed.repeat_start   = directed_rows[r].start;
                typed.repeat_count   = directed_rows[r].count;
                feed_symbol(beat, directed_rows[r].check, typed);
            end
        end

        typed        = '0;
        phase_no     = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            len = pick_block_length(phase_no);
            write_block_length(len);
            enabled = len != 0 && len <= MAX_BLOCK;
            target  = !enabled ? 20 : (len == MAX_BLOCK ? 260 : 80);
            build_phase(len, target);
            send_steady = (phase_no % 4 == 3) || (phase_no == PRESSURE_PHASE);
            recv_steady = (phase_no % 4 == 3);
            // stall the result side and keep offering beats
            if (phase_no == PRESSURE_PHASE)
                hold_req = 1'b1;
            foreach (phase_beats[i]) begin
                if (random_items >= RANDOM_ITEMS)
                    break;
                if (phase_no == PAUSE_PHASE && i == phase_beats.size() / 2)
                    settle_results();
                feed_symbol(phase_beats[i], CHK_MODEL, typed);
                random_items++;
            end
            phase_no++;
        end

        settle_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run covered %0d symbols in %0d phases, %0d block length writes",
                 symbols_fed, phase_no, lengths_written);
        $display("%0d repeats reported, %0d mismatches, %0d cycles",
                 repeats_seen, mismatches, cycle_count);
        if (mismatches == 0 && pending_repeats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/trd_pkg.sv
rtl/trd_ram.sv
rtl/trd_core.sv
rtl/tandem_repeat_detector.sv
sim/testbench.sv
